### rtl/vwts_pkg.sv
`default_nettype none
package vwts_pkg;

	localparam int TileW     = 9;
	localparam int FrameW    = 13;
	localparam int DividendW = 40;
	localparam int DivisorW  = 17;
	localparam int DivCntW   = 6;
	localparam int MulBits   = 8;
	localparam int MulCntW   = 4;
	localparam int ProdW     = 12;
	localparam int RandShift = 24;

	localparam logic [2:0] REG_TILES_ACROSS = 3'd0;
	localparam logic [2:0] REG_TILES_DOWN   = 3'd1;
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
	localparam logic [2:0] REG_STEP_MODE    = 3'd4;

	localparam logic [1:0] MODE_SCAN   = 2'd0;
	localparam logic [1:0] MODE_RANDOM = 2'd1;
	localparam logic [1:0] MODE_SPIRAL = 2'd2;

	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_UP    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVW,
		ST_DIVH,
		ST_PICK,
		ST_DIVL,
		ST_SPIRAL,
		ST_RAND,
		ST_MODN,
		ST_DIVI,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DivCntW-1:0]   nbits;
		logic [DividendW-1:0] dividend;
		logic [DivisorW-1:0]  divisor;
	} div_cmd_t;

	typedef struct packed {
		logic                 done;
		logic [DividendW-1:0] quot;
		logic [DivisorW-1:0]  rem;
	} div_res_t;

endpackage
`default_nettype wire

### rtl/vwts_div.sv
`default_nettype none
module vwts_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire vwts_pkg::div_cmd_t cmd,
	output vwts_pkg::div_res_t  res
);
	import vwts_pkg::*;

	logic [DividendW-1:0] dvd_q;
	logic [DivisorW-1:0]  rem_q;
	logic [DivisorW-1:0]  dsr_q;
	logic [DivCntW-1:0]   cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DivisorW:0]    rem_ext;
	logic [DivisorW:0]    diff;
	logic                 ge;

	assign rem_ext = {rem_q, dvd_q[DividendW-1]};
	assign diff    = rem_ext - {1'b0, dsr_q};
	assign ge      = rem_ext >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmd.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DivCntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= cmd.dividend;
			dsr_q <= cmd.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DividendW-2:0], ge};
			rem_q <= ge ? diff[DivisorW-1:0] : rem_ext[DivisorW-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = dvd_q;
	assign res.rem  = rem_q;

endmodule
`default_nettype wire

### rtl/vwts_mul.sv
`default_nettype none
module vwts_mul (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [vwts_pkg::ProdW-1:0]    multiplicand,
	input  wire [vwts_pkg::MulBits-1:0]  multiplier,
	input  wire [vwts_pkg::ProdW-1:0]    addend,
	output logic                         done,
	output logic [vwts_pkg::ProdW-1:0]   product
);
	import vwts_pkg::*;

	logic [ProdW-1:0]   a_q;
	logic [MulBits-1:0] b_q;
	logic [ProdW-1:0]   acc_q;
	logic [MulCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= MulCntW'(MulBits);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == MulCntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= multiplicand;
			b_q   <= multiplier;
			acc_q <= addend;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[ProdW-2:0], 1'b0};
			b_q <= {1'b0, b_q[MulBits-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

### rtl/video_wall_tile_sequencer_top.sv
`default_nettype none
// Once per frame this block picks the wall tile that receives the downscaled frame and returns
// its index, grid position, pixel position and even size; a word whose tile size would be zero
// comes back with the skip flag in tuser, all other fields zero, and no change of state. All
// division is done by one shared restoring divider, one quotient bit per cycle, and the pixel
// offsets by two bit-serial multipliers of eight steps. The block has a scan, a tile-zero, a
// random and a spiral mode; the random mode takes a 40-bit modulo, and the spiral mode first
// splits the previous tile, when there is one, into row and column. The block takes one item
// at a time; the finished result waits in an output register, so a new item is taken while the
// previous result is still unclaimed. Configuration may only be written while idle.
module video_wall_tile_sequencer_top #(
	parameter int MAX_TILES_SIDE = 256,
	parameter int MAX_FRAME_SIDE = 4096
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	// random_word [63:0]
	input  wire  [63:0]                   s_tdata,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	// tile_index [15:0], tile_col [23:16], tile_row [31:24], tile_x [43:32],
	// tile_y [55:44], tile_width [68:56], tile_height [81:69], zero fill [87:82]
	output logic [87:0]                   m_tdata,
	// skipped [0]
	output logic                          m_tuser,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [2:0]                    cfg_index,
	input  wire  [vwts_pkg::FrameW-1:0]   cfg_data
);
	import vwts_pkg::*;

	logic [TileW-1:0]  tiles_across_q;
	logic [TileW-1:0]  tiles_down_q;
	logic [FrameW-1:0] frame_width_q;
	logic [FrameW-1:0] frame_height_q;
	logic [1:0]        step_mode_q;

	logic [TileW-1:0]  ta;
	logic [TileW-1:0]  td;
	logic [FrameW-1:0] fw;
	logic [FrameW-1:0] fh;

	state_t state_q, state_d;
	logic   launched_q;
	logic   is_div;
	logic   op_state;
	logic   op_done;

	div_cmd_t div_cmd;
	div_res_t div_res;
	logic     mul_start;
	logic     mul_done_x;
	logic     mul_done_y;
	logic [ProdW-1:0] prod_x;
	logic [ProdW-1:0] prod_y;

	logic [DividendW-1:0] rw_q;
	logic [DivisorW-1:0]  n_q;
	logic [FrameW-1:0]    pw_q;
	logic [FrameW-1:0]    ph_q;
	logic [TileW-1:0]     ox_q;
	logic [TileW-1:0]     oy_q;
	logic [DivisorW-1:0]  idx_raw_q;
	logic [15:0]          idx_q;
	logic [15:0]          lrow_q;
	logic [TileW-1:0]     lcol_q;
	logic [7:0]           row_q;
	logic [7:0]           col_q;

	logic [15:0] fc_q;
	logic [15:0] last_q;
	logic        last_none_q;
	logic [1:0]  dir_q;

	logic [87:0] out_data_q;
	logic        out_user_q;
	logic        out_valid_q;

	logic                skip_w;
	logic [TileW:0]      off_sum;
	logic [DivisorW-1:0] fc_next;

	logic signed [19:0] sr, sc, sta, sdn, sp_prev, sp_idx;
	logic [1:0]         sp_dir;
	logic               sp_zero;
	logic [DivisorW-1:0] sp_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiles_across_q <= TileW'(3);
			tiles_down_q   <= TileW'(3);
			frame_width_q  <= FrameW'(640);
			frame_height_q <= FrameW'(480);
			step_mode_q    <= MODE_SCAN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TILES_ACROSS: tiles_across_q <= cfg_data[TileW-1:0];
				REG_TILES_DOWN:   tiles_down_q   <= cfg_data[TileW-1:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_STEP_MODE:    step_mode_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ta = tiles_across_q;
		if (tiles_across_q == '0) begin
			ta = TileW'(1);
		end else if (32'(tiles_across_q) > MAX_TILES_SIDE) begin
			ta = TileW'(MAX_TILES_SIDE);
		end
		td = tiles_down_q;
		if (tiles_down_q == '0) begin
			td = TileW'(1);
		end else if (32'(tiles_down_q) > MAX_TILES_SIDE) begin
			td = TileW'(MAX_TILES_SIDE);
		end
		fw = frame_width_q;
		if (32'(frame_width_q) > MAX_FRAME_SIDE) begin
			fw = FrameW'(MAX_FRAME_SIDE);
		end
		fh = frame_height_q;
		if (32'(frame_height_q) > MAX_FRAME_SIDE) begin
			fh = FrameW'(MAX_FRAME_SIDE);
		end
	end

	assign skip_w   = (pw_q == '0) || (ph_q == '0);
	assign is_div   = state_q inside {ST_DIVW, ST_DIVH, ST_DIVL, ST_RAND, ST_MODN, ST_DIVI};
	assign op_state = is_div || (state_q == ST_MUL);
	assign op_done  = launched_q && (is_div ? div_res.done : mul_done_x);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DIVW;
				end
			end
			ST_DIVW: if (op_done) state_d = ST_DIVH;
			ST_DIVH: if (op_done) state_d = ST_PICK;
			ST_PICK: begin
				if (skip_w) begin
					state_d = ST_DONE;
				end else begin
					case (step_mode_q)
						MODE_SCAN:   state_d = ST_MODN;
						MODE_RANDOM: state_d = ST_RAND;
						MODE_SPIRAL: state_d = last_none_q ? ST_MODN : ST_DIVL;
						default:     state_d = ST_DIVI;
					endcase
				end
			end
			ST_DIVL:   if (op_done) state_d = ST_SPIRAL;
			ST_SPIRAL: state_d = ST_MODN;
			ST_RAND:   if (op_done) state_d = ST_DIVI;
			ST_MODN:   if (op_done) state_d = ST_DIVI;
			ST_DIVI:   if (op_done) state_d = ST_MUL;
			ST_MUL:    if (op_done) state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = (state_q == ST_IDLE);
		mul_start        = (state_q == ST_MUL) && !launched_q;
		div_cmd.start    = is_div && !launched_q;
		div_cmd.nbits    = DivCntW'(FrameW);
		div_cmd.dividend = {fw, {(DividendW-FrameW){1'b0}}};
		div_cmd.divisor  = DivisorW'(ta);
		case (state_q)
			ST_DIVH: begin
				div_cmd.dividend = {fh, {(DividendW-FrameW){1'b0}}};
				div_cmd.divisor  = DivisorW'(td);
			end
			ST_DIVL: begin
				div_cmd.nbits    = DivCntW'(16);
				div_cmd.dividend = {last_q, {(DividendW-16){1'b0}}};
			end
			ST_RAND: begin
				div_cmd.nbits    = DivCntW'(DividendW);
				div_cmd.dividend = rw_q;
				div_cmd.divisor  = n_q;
			end
			ST_MODN: begin
				div_cmd.nbits    = DivCntW'(DivisorW);
				div_cmd.dividend = {idx_raw_q, {(DividendW-DivisorW){1'b0}}};
				div_cmd.divisor  = n_q;
			end
			ST_DIVI: begin
				div_cmd.nbits    = DivCntW'(16);
				div_cmd.dividend = {idx_q, {(DividendW-16){1'b0}}};
			end
			default: ;
		endcase
	end

	vwts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.res    (div_res)
	);

	vwts_mul u_mul_x (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplicand (pw_q[ProdW-1:0]),
		.multiplier   (col_q),
		.addend       (ProdW'(ox_q)),
		.done         (mul_done_x),
		.product      (prod_x)
	);

	vwts_mul u_mul_y (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplicand (ph_q[ProdW-1:0]),
		.multiplier   (row_q),
		.addend       (ProdW'(oy_q)),
		.done         (mul_done_y),
		.product      (prod_y)
	);

	// The spiral moves one step from the previous tile, using that tile's own row and column.
	always_comb begin
		sr      = signed'(20'(lrow_q));
		sc      = signed'(20'(lcol_q));
		sta     = signed'(20'(ta));
		sdn     = signed'(20'(td));
		sp_prev = signed'(20'(last_q));
		sp_idx  = sp_prev;
		sp_dir  = dir_q;
		sp_zero = 1'b0;
		if (sp_dir == DIR_RIGHT) begin
			if (sc >= sta - 20'sd1 - sr) sp_dir = DIR_DOWN;
			else sp_idx = sp_idx + 20'sd1;
		end
		if (sp_dir == DIR_DOWN) begin
			if (sr >= sc - (sta - sdn)) sp_dir = DIR_LEFT;
			else sp_idx = sp_idx + sta;
		end
		if (sp_dir == DIR_LEFT) begin
			if (sc <= (sta - sr - 20'sd1) - (sta - sdn)) begin
				sp_dir = DIR_UP;
				if (sr <= sc + 20'sd1) begin
					sp_dir  = DIR_RIGHT;
					sp_zero = 1'b1;
				end
			end else begin
				sp_idx = sp_idx - 20'sd1;
			end
		end
		if (sp_dir == DIR_UP) begin
			if (sr <= sc + 20'sd1) begin
				sp_dir = DIR_RIGHT;
				if (sc < sta - 20'sd1 - sr) sp_idx = sp_idx + 20'sd1;
			end else begin
				sp_idx = sp_idx - sta;
			end
		end
		if (sp_zero || sp_idx == sp_prev) begin
			sp_idx = '0;
			sp_dir = DIR_RIGHT;
		end
		if (sp_idx < 0) begin
			sp_idx = '0;
		end
		sp_res = sp_idx[DivisorW-1:0];
	end

	assign off_sum = (TileW+1)'(div_res.rem[TileW-1:0])
		+ (div_res.quot[0] ? (TileW+1)'((state_q == ST_DIVH) ? td : ta) : '0);
	assign fc_next = DivisorW'(fc_q) + DivisorW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launched_q  <= 1'b0;
			fc_q        <= '0;
			last_q      <= '0;
			last_none_q <= 1'b1;
			dir_q       <= DIR_RIGHT;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			launched_q <= op_state && !op_done;
			if (state_q == ST_PICK && !skip_w && step_mode_q == MODE_SPIRAL && last_none_q) begin
				dir_q <= DIR_RIGHT;
			end
			if (state_q == ST_SPIRAL) begin
				dir_q <= sp_dir;
			end
			if (state_q == ST_DIVI && op_done) begin
				last_q      <= idx_q;
				last_none_q <= 1'b0;
				fc_q        <= (fc_next == n_q || fc_next[DivisorW-1]) ? '0 : fc_next[15:0];
			end
			if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rw_q <= s_tdata[63:RandShift];
				n_q  <= DivisorW'(ta) * DivisorW'(td);
			end
			ST_DIVW: begin
				if (op_done) begin
					pw_q <= {div_res.quot[FrameW-1:1], 1'b0};
					ox_q <= off_sum[TileW:1];
				end
			end
			ST_DIVH: begin
				if (op_done) begin
					ph_q <= {div_res.quot[FrameW-1:1], 1'b0};
					oy_q <= off_sum[TileW:1];
				end
			end
			ST_PICK: begin
				idx_raw_q <= (step_mode_q == MODE_SCAN) ? DivisorW'(fc_q) : '0;
				idx_q     <= '0;
			end
			ST_DIVL: begin
				if (op_done) begin
					lrow_q <= div_res.quot[15:0];
					lcol_q <= div_res.rem[TileW-1:0];
				end
			end
			ST_SPIRAL: idx_raw_q <= sp_res;
			ST_RAND:   if (op_done) idx_q <= div_res.rem[15:0];
			ST_MODN:   if (op_done) idx_q <= div_res.rem[15:0];
			ST_DIVI: begin
				if (op_done) begin
					row_q <= div_res.quot[7:0];
					col_q <= div_res.rem[7:0];
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					if (skip_w) begin
						out_data_q <= '0;
						out_user_q <= 1'b1;
					end else begin
						out_data_q <= {6'b0, ph_q, pw_q, prod_y, prod_x, row_q, col_q, idx_q};
						out_user_q <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again straight after a word was accepted");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("skipped word carries non-zero fields");

	a_even_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tdata[56] && !m_tdata[69]
			&& m_tdata[68:56] != '0 && m_tdata[81:69] != '0)
		else $error("placed tile has an odd or zero size");

	a_single_launch: assert property (@(posedge clk) disable iff (!arst_n)
		div_cmd.start |=> !div_cmd.start && !mul_start && !s_tready)
		else $error("divider started twice for one step");

	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done_x == mul_done_y)
		else $error("offset multipliers out of step");

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import vwts_pkg::*;

	localparam logic [1:0] MODE_ZERO        = 2'd3;
	localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;
	localparam int         RandomFrames     = 1700;
	localparam int         SettleCycles     = 200;
	localparam int         CycleLimit       = 1000000;
	localparam int         MAX_TILES_SIDE_TB = 256;
	localparam int         MAX_FRAME_SIDE_TB = 4096;

	typedef struct packed {
		logic        skipped;
		logic [15:0] index;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [11:0] x;
		logic [11:0] y;
		logic [12:0] width;
		logic [12:0] height;
	} tile_t;

	typedef struct {
		bit          is_reg;
		logic [2:0]  reg_index;
		logic [12:0] reg_value;
		logic [63:0] word;
		bit          known;
		tile_t       placement;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [12:0] cfg_data;

	video_wall_tile_sequencer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	logic [8:0]  wall_across;
	logic [8:0]  wall_down;
	logic [12:0] wall_frame_w;
	logic [12:0] wall_frame_h;
	logic [1:0]  wall_mode;
	int          frame_count;
	int          last_tile;
	logic [1:0]  spiral_dir;

	tile_t       placements_due[$];
	script_row_t opening_script[$];
	int          error_count;
	int          cycle_count;
	bit          tx_burst;
	bit          rx_burst;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("video_wall_tile_sequencer_top verification failed");
			$finish;
		end
	end

	function automatic int clamp_side(int v, int top);
		if (v < 1)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic int spiral_advance(int ta, int td);
		int prev;
		int p;
		int row;
		int col;
		prev = last_tile;
		p = prev;
		if (p < 0) begin
			spiral_dir = DIR_RIGHT;
			return 0;
		end
		row = p / ta;
		col = p - row * ta;
		if (spiral_dir == DIR_RIGHT) begin
			if (col >= ta - 1 - row)
				spiral_dir = DIR_DOWN;
			else
				p++;
		end
		if (spiral_dir == DIR_DOWN) begin
			if (row >= col - (ta - td))
				spiral_dir = DIR_LEFT;
			else
				p += ta;
		end
		if (spiral_dir == DIR_LEFT) begin
			if (col <= (ta - row - 1) - (ta - td)) begin
				spiral_dir = DIR_UP;
				if (row <= col + 1) begin
					spiral_dir = DIR_RIGHT;
					return 0;
				end
			end else begin
				p--;
			end
		end
		if (spiral_dir == DIR_UP) begin
			if (row <= col + 1) begin
				spiral_dir = DIR_RIGHT;
				if (col < ta - 1 - row)
					p++;
			end else begin
				p -= ta;
			end
		end
		if (p == prev) begin
			p = 0;
			spiral_dir = DIR_RIGHT;
		end
		if (p < 0)
			p = 0;
		return p;
	endfunction

	function automatic tile_t place_frame(logic [63:0] word);
		int    ta;
		int    td;
		int    fw;
		int    fh;
		int    n;
		int    pw;
		int    ph;
		int    ox;
		int    oy;
		int    pick;
		int    row;
		int    col;
		int    upcoming;
		tile_t t;
		ta = clamp_side(int'(wall_across), MAX_TILES_SIDE_TB);
		td = clamp_side(int'(wall_down), MAX_TILES_SIDE_TB);
		fw = (int'(wall_frame_w) > MAX_FRAME_SIDE_TB) ? MAX_FRAME_SIDE_TB : int'(wall_frame_w);
		fh = (int'(wall_frame_h) > MAX_FRAME_SIDE_TB) ? MAX_FRAME_SIDE_TB : int'(wall_frame_h);
		n = ta * td;
		pw = (fw / ta) & ~1;
		ph = (fh / td) & ~1;
		t = '0;
		if (pw == 0 || ph == 0) begin
			t.skipped = 1'b1;
			return t;
		end
		ox = (fw - pw * ta) >> 1;
		oy = (fh - ph * td) >> 1;
		case (wall_mode)
			MODE_SCAN:   pick = frame_count;
			MODE_RANDOM: pick = int'((word >> RandShift) % 64'(n));
			MODE_SPIRAL: pick = spiral_advance(ta, td);
			default:     pick = 0;
		endcase
		pick = pick % n;
		last_tile = pick;
		upcoming = frame_count + 1;
		if (upcoming == n || upcoming > 65535)
			upcoming = 0;
		frame_count = upcoming;
		row = pick / ta;
		col = pick - row * ta;
		t.index  = 16'(pick);
		t.col    = 8'(col);
		t.row    = 8'(row);
		t.x      = 12'(ox + pw * col);
		t.y      = 12'(oy + ph * row);
		t.width  = 13'(pw);
		t.height = 13'(ph);
		return t;
	endfunction

	function automatic tile_t tile_at(logic skipped, int index, int col, int row, int x, int y,
			int width, int height);
		tile_t t;
		t.skipped = skipped;
		t.index   = 16'(index);
		t.col     = 8'(col);
		t.row     = 8'(row);
		t.x       = 12'(x);
		t.y       = 12'(y);
		t.width   = 13'(width);
		t.height  = 13'(height);
		return t;
	endfunction

	task automatic script_reg(logic [2:0] index, logic [12:0] value);
		script_row_t r;
		r = '{default: '0};
		r.is_reg = 1'b1;
		r.reg_index = index;
		r.reg_value = value;
		opening_script.push_back(r);
	endtask

	task automatic script_frame(logic [63:0] word, bit known, tile_t placement);
		script_row_t r;
		r = '{default: '0};
		r.word = word;
		r.known = known;
		r.placement = placement;
		opening_script.push_back(r);
	endtask

	function automatic void check_field(string name, longint expected, longint actual);
		if (expected != actual) begin
			$error("%s mismatch: expected %0d, got %0d", name, expected, actual);
			error_count++;
		end
	endfunction

	task automatic write_reg(logic [2:0] index, logic [12:0] value);
		while (placements_due.size() != 0)
			@(negedge clk);
		cfg_index = index;
		cfg_data  = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (index)
			REG_TILES_ACROSS: wall_across  = value[TileW-1:0];
			REG_TILES_DOWN:   wall_down    = value[TileW-1:0];
			REG_FRAME_WIDTH:  wall_frame_w = value;
			REG_FRAME_HEIGHT: wall_frame_h = value;
			REG_STEP_MODE:    wall_mode    = value[1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_frame(logic [63:0] word, bit known, tile_t placement);
		int    gap;
		tile_t predicted;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = word;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = place_frame(word);
		placements_due.push_back(known ? placement : predicted);
		@(negedge clk);
	endtask

	function automatic logic [12:0] pick_tiles();
		case ($urandom_range(0, 9))
			0:       return 13'd0;
			1:       return 13'd256;
			2:       return 13'($urandom_range(257, 511));
			3:       return 13'd1;
			default: return 13'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [12:0] pick_frame_side();
		case ($urandom_range(0, 11))
			0:       return 13'd0;
			1:       return 13'd4096;
			2:       return 13'($urandom_range(4097, 8191));
			3:       return 13'($urandom_range(1, 15));
			default: return 13'($urandom_range(16, 4096));
		endcase
	endfunction

	initial begin
		int          sent;
		int          phase_len;
		logic [1:0]  mode_pick;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		error_count = 0;
		cycle_count = 0;
		tx_burst    = 1'b0;
		rx_burst    = 1'b0;
		wall_across  = 9'd3;
		wall_down    = 9'd3;
		wall_frame_w = 13'd640;
		wall_frame_h = 13'd480;
		wall_mode    = MODE_SCAN;
		frame_count  = 0;
		last_tile    = -1;
		spiral_dir   = DIR_RIGHT;

		// The grid after reset is 3 by 3 tiles of 212 by 160 pixels, offset 2 pixels across.
		script_frame(64'h0, 1, tile_at(0, 0, 0, 0, 2, 0, 212, 160));
		script_frame('1, 1, tile_at(0, 1, 1, 0, 214, 0, 212, 160));
		script_frame(64'h5555_5555_5555_5555, 1, tile_at(0, 2, 2, 0, 426, 0, 212, 160));
		script_frame(64'hAAAA_AAAA_AAAA_AAAA, 1, tile_at(0, 3, 0, 1, 2, 160, 212, 160));
		script_reg(REG_STEP_MODE, 13'(MODE_ZERO));
		script_frame(64'h1234_5678_9ABC_DEF0, 1, tile_at(0, 0, 0, 0, 2, 0, 212, 160));
		script_reg(REG_STEP_MODE, 13'(MODE_RANDOM));
		script_frame('1, 1, tile_at(0, 6, 0, 2, 2, 320, 212, 160));
		script_frame(64'h0000_0000_00FF_FFFF, 1, tile_at(0, 0, 0, 0, 2, 0, 212, 160));
		script_frame(64'h0000_0000_0100_0000, 1, tile_at(0, 1, 1, 0, 214, 0, 212, 160));
		script_frame(64'h8000_0000_0000_0000, 0, '0);
		script_reg(REG_STEP_MODE, 13'(MODE_SPIRAL));
		for (int i = 0; i < 10; i++)
			script_frame({$urandom, $urandom}, 0, '0);
		script_reg(REG_FRAME_WIDTH, 13'd0);
		script_frame('1, 1, tile_at(1, 0, 0, 0, 0, 0, 0, 0));
		script_reg(REG_FRAME_WIDTH, 13'd8191);
		script_reg(REG_FRAME_HEIGHT, 13'd1);
		script_frame(64'h0, 1, tile_at(1, 0, 0, 0, 0, 0, 0, 0));
		script_reg(REG_TILES_ACROSS, 13'd0);
		script_reg(REG_TILES_DOWN, 13'd511);
		script_reg(REG_FRAME_HEIGHT, 13'd4096);
		script_reg(REG_STEP_MODE, 13'(MODE_SCAN));
		script_frame(64'h0, 0, '0);
		script_frame('1, 0, '0);
		script_reg(REG_TILES_ACROSS, 13'd256);
		script_reg(REG_TILES_DOWN, 13'd256);
		script_reg(REG_FRAME_WIDTH, 13'd4096);
		script_reg(REG_STEP_MODE, 13'(MODE_SPIRAL));
		script_frame(64'h0, 0, '0);
		script_frame('1, 0, '0);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening_script[i]) begin
			if (opening_script[i].is_reg) begin
				s_tvalid = 1'b0;
				write_reg(opening_script[i].reg_index, opening_script[i].reg_value);
			end else begin
				send_frame(opening_script[i].word, opening_script[i].known,
					opening_script[i].placement);
			end
		end

		sent = 0;
		while (sent < RandomFrames) begin
			s_tvalid = 1'b0;
			write_reg(REG_TILES_ACROSS, pick_tiles());
			write_reg(REG_TILES_DOWN, pick_tiles());
			write_reg(REG_FRAME_WIDTH, pick_frame_side());
			write_reg(REG_FRAME_HEIGHT, pick_frame_side());
			case ($urandom_range(0, 5))
				0:       mode_pick = MODE_SCAN;
				1:       mode_pick = MODE_RANDOM;
				2:       mode_pick = MODE_ZERO;
				default: mode_pick = MODE_SPIRAL;
			endcase
			write_reg(REG_STEP_MODE, 13'(mode_pick));
			if ($urandom_range(0, 3) == 0)
				write_reg(3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
					13'($urandom_range(0, 8191)));
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(40, 120);
			for (int i = 0; i < phase_len && sent < RandomFrames; i++) begin
				send_frame({$urandom, $urandom}, 0, '0);
				sent++;
			end
		end

		s_tvalid = 1'b0;
		rx_burst = 1'b0;
		while (placements_due.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		if (error_count == 0)
			$display("video_wall_tile_sequencer_top verification clean");
		else
			$display("video_wall_tile_sequencer_top verification failed");
		$finish;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = rx_burst ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		tile_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (placements_due.size() == 0) begin
				$error("result word with no placement outstanding");
				error_count++;
			end else begin
				due = placements_due.pop_front();
				check_field("skipped", due.skipped, m_tuser);
				check_field("tile_index", due.index, m_tdata[15:0]);
				check_field("tile_col", due.col, m_tdata[23:16]);
				check_field("tile_row", due.row, m_tdata[31:24]);
				check_field("tile_x", due.x, m_tdata[43:32]);
				check_field("tile_y", due.y, m_tdata[55:44]);
				check_field("tile_width", due.width, m_tdata[68:56]);
				check_field("tile_height", due.height, m_tdata[81:69]);
			end
		end
	end

endmodule
